[hw/rtl/ssba_pkg.sv]
// ----------------------------------------------------------------------------
// ssba_pkg
// Shared types and codes for the swap slot bitmap allocator: request and
// response transaction layouts, request codes and status codes.
// ----------------------------------------------------------------------------
package ssba_pkg;

  localparam int FUNC_W    = 2;
  localparam int SLOT_W    = 15;
  localparam int INDEX_W   = 10;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 15;

  // Second-level summary: one bit per map word, grouped in words of this size
  localparam int SUM_BITS  = 32;
  localparam int SUM_IDX_W = 5;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NONE_FREE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BITMAP_BAD = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [SLOT_W-1:0]  slot;
    logic [INDEX_W-1:0] word_index;
    logic [DATA_W-1:0]  word_data;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   granted_slot;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_slots;
  } rsp_t;

endpackage

[hw/rtl/swap_slot_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// swap_slot_bitmap_allocator
// A request that touches the map (allocate, in-range free, in-range load)
// steps through the summary-read, word-read, modify/write and response
// sequence on the two memories; any other request goes straight from idle to
// the response stage. A new request is taken only in the idle state, once the
// last one has left the response stage. A parked response lets the next request
// start; a second one waits in the response stage until the output frees up.
// Reset: clears enable, free count and group summary; no memory clearing pass.
// ----------------------------------------------------------------------------
module swap_slot_bitmap_allocator #(
  parameter int SLOT_COUNT    = 32768,
  parameter int MAP_WORD_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data,
  input  logic           in_valid,
  output logic           in_ready,
  input  ssba_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ssba_pkg::rsp_t out_data
);
  import ssba_pkg::*;

  // --------------------------------------------------------------------------
  // Geometry
  // --------------------------------------------------------------------------
  localparam int MAP_WORDS = (SLOT_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int GROUPS    = (MAP_WORDS + SUM_BITS - 1) / SUM_BITS;
  localparam int GA_W      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int BIT_W     = $clog2(MAP_WORD_BITS);
  localparam int POP_W     = $clog2(MAP_WORD_BITS + 1);
  localparam int LAST_BITS = SLOT_COUNT - (MAP_WORDS - 1) * MAP_WORD_BITS;
  localparam int SN_W      = $clog2(MAP_WORDS * MAP_WORD_BITS) + 1;
  localparam int WPAD_W    = WA_W + SUM_IDX_W;

  // slot / MAP_WORD_BITS by reciprocal; exact over the whole slot field range
  localparam int     RECIP_SH = SLOT_W + BIT_W + 1;
  localparam longint RECIP    =
    ((longint'(1) << RECIP_SH) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int     PROD_W   = SLOT_W + RECIP_SH + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_SUM, ST_WORD, ST_OUT} state_t;
  typedef enum logic [1:0] {OP_ALLOC, OP_FREE, OP_LOAD} op_t;

  // --------------------------------------------------------------------------
  // Helpers: lowest set bit searches and population count
  // --------------------------------------------------------------------------
  function automatic logic [GA_W-1:0] low_group(input logic [GROUPS-1:0] v);
    logic [GA_W-1:0] idx;
    idx = '0;
    for (int i = GROUPS - 1; i >= 0; i--) begin
      if (v[i]) idx = GA_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [SUM_IDX_W-1:0] low_sum(input logic [SUM_BITS-1:0] v);
    logic [SUM_IDX_W-1:0] idx;
    idx = '0;
    for (int i = SUM_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = SUM_IDX_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [BIT_W-1:0] low_bit(input logic [MAP_WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [POP_W-1:0] ones(input logic [MAP_WORD_BITS-1:0] v);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAP_WORD_BITS; i++) begin
      n = n + POP_W'(v[i]);
    end
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t                    state;
  op_t                       op;
  logic                      map_enabled;
  logic [COUNT_W-1:0]        free_total;
  // First-level summary: bit g set when group g has any nonzero map word.
  // A clear bit masks whatever the summary memory holds for that group, and
  // a clear summary bit masks the map word, so reset needs no memory sweep.
  logic [GROUPS-1:0]         grp_map;

  logic [GA_W-1:0]           g_q;
  logic [SUM_IDX_W-1:0]      sb_q;
  logic [WA_W-1:0]           w_q;
  logic [BIT_W-1:0]          bit_q;
  logic [SLOT_W-1:0]         slot_q;
  logic [MAP_WORD_BITS-1:0]  load_word;
  logic [SUM_BITS-1:0]       sum_q;
  rsp_t                      res;

  // Memories: map words and per-group summary words, registered read
  logic [MAP_WORD_BITS-1:0]  map_mem [MAP_WORDS];
  logic [MAP_WORD_BITS-1:0]  map_rd;
  logic                      map_re;
  logic [WA_W-1:0]           map_raddr;
  logic                      map_we;
  logic [MAP_WORD_BITS-1:0]  map_wdata;

  logic [SUM_BITS-1:0]       sum_mem [GROUPS];
  logic [SUM_BITS-1:0]       sum_rd;
  logic                      sum_re;
  logic [GA_W-1:0]           sum_raddr;
  logic                      sum_we;
  logic [SUM_BITS-1:0]       sum_wdata;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[w_q] <= map_wdata;
    if (map_re) map_rd <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[g_q] <= sum_wdata;
    if (sum_re) sum_rd <= sum_mem[sum_raddr];
  end

  // --------------------------------------------------------------------------
  // Request decode (idle cycle)
  // --------------------------------------------------------------------------
  logic                     in_fire;
  logic [PROD_W-1:0]        quot_prod;
  logic [WA_W-1:0]          slot_word;
  logic [WA_W-1:0]          req_word;
  logic [WPAD_W-1:0]        req_wpad;
  logic [GA_W-1:0]          req_grp;
  logic [SUM_IDX_W-1:0]     req_sb;
  logic [GA_W-1:0]          alloc_grp;
  logic                     go_alloc;
  logic                     go_free;
  logic                     go_load;
  logic [MAP_WORD_BITS-1:0] load_mask;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;

  assign quot_prod = PROD_W'(in_data.slot) * PROD_W'(RECIP);
  assign slot_word = WA_W'(quot_prod >> RECIP_SH);
  assign req_word  = (in_data.func == FUNC_LOAD) ? WA_W'(in_data.word_index) : slot_word;
  assign req_wpad  = WPAD_W'(req_word);
  assign req_grp   = GA_W'(req_wpad >> SUM_IDX_W);
  assign req_sb    = req_wpad[SUM_IDX_W-1:0];
  assign alloc_grp = low_group(grp_map);

  assign go_alloc = (in_data.func == FUNC_ALLOC) && map_enabled && (|grp_map);
  assign go_free  = (in_data.func == FUNC_FREE) && map_enabled &&
                    (in_data.slot != '0) && (int'(in_data.slot) < SLOT_COUNT);
  assign go_load  = (in_data.func == FUNC_LOAD) && (int'(in_data.word_index) < MAP_WORDS);

  // Loaded bits that name slot 0 or slots past the end are dropped
  always_comb begin
    load_mask = '1;
    if (int'(in_data.word_index) == MAP_WORDS - 1) begin
      for (int i = 0; i < MAP_WORD_BITS; i++) begin
        if (i >= LAST_BITS) load_mask[i] = 1'b0;
      end
    end
    if (in_data.word_index == '0) load_mask[0] = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Summary stage
  // --------------------------------------------------------------------------
  logic [SUM_BITS-1:0]  sum_eff;
  logic [SUM_IDX_W-1:0] sum_low;
  logic [WA_W-1:0]      alloc_word;
  logic [SLOT_W:0]      word_base;
  logic [SLOT_W:0]      rem_full;

  assign sum_eff    = grp_map[g_q] ? sum_rd : '0;
  assign sum_low    = low_sum(sum_eff);
  assign alloc_word = WA_W'({g_q, sum_low});
  assign word_base  = (SLOT_W+1)'(w_q) * (SLOT_W+1)'(MAP_WORD_BITS);
  assign rem_full   = {1'b0, slot_q} - word_base;

  // --------------------------------------------------------------------------
  // Word stage: modify and write back
  // --------------------------------------------------------------------------
  logic [MAP_WORD_BITS-1:0] word_eff;
  logic [BIT_W-1:0]         alloc_bit;
  logic [BIT_W-1:0]         sel_bit;
  logic [MAP_WORD_BITS-1:0] one_hot;
  logic                     free_bad;
  logic [SUM_BITS-1:0]      sb_hot;
  logic [COUNT_W-1:0]       free_after;
  logic [SN_W-1:0]          granted_full;

  assign word_eff     = sum_q[sb_q] ? map_rd : '0;
  assign alloc_bit    = low_bit(word_eff);
  assign sel_bit      = (op == OP_ALLOC) ? alloc_bit : bit_q;
  assign one_hot      = MAP_WORD_BITS'(1) << sel_bit;
  assign free_bad     = (op == OP_FREE) && ((word_eff & one_hot) != '0);
  assign sb_hot       = SUM_BITS'(1) << sb_q;
  assign granted_full = SN_W'(w_q) * SN_W'(MAP_WORD_BITS) + SN_W'(alloc_bit);

  always_comb begin
    unique case (op)
      OP_ALLOC: begin
        map_wdata  = word_eff & ~one_hot;
        free_after = free_total - COUNT_W'(1);
      end
      OP_FREE: begin
        map_wdata  = word_eff | one_hot;
        free_after = free_bad ? free_total : free_total + COUNT_W'(1);
      end
      OP_LOAD: begin
        map_wdata  = load_word;
        free_after = free_total - COUNT_W'(ones(word_eff)) + COUNT_W'(ones(load_word));
      end
      default: begin
        map_wdata  = word_eff;
        free_after = free_total;
      end
    endcase
    sum_wdata = (sum_q & ~sb_hot) | ((|map_wdata) ? sb_hot : '0);
    map_we    = (state == ST_WORD) && !free_bad;
    sum_we    = map_we;
  end

  // Memory reads: summary (and map word for free/load) in the idle cycle,
  // map word for allocate once its group summary is known.
  // Writes land at the end of the word stage; the next request cannot issue
  // a read before the response stage, so no forwarding path is needed.
  always_comb begin
    sum_re    = 1'b0;
    map_re    = 1'b0;
    sum_raddr = req_grp;
    map_raddr = req_word;
    if (in_fire) begin
      if (go_alloc) begin
        sum_re    = 1'b1;
        sum_raddr = alloc_grp;
      end
      if (go_free || go_load) begin
        sum_re = 1'b1;
        map_re = 1'b1;
      end
    end
    if (state == ST_SUM && op == OP_ALLOC) begin
      map_re    = 1'b1;
      map_raddr = alloc_word;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and response register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      map_enabled <= 1'b0;
      free_total  <= '0;
      grp_map     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) map_enabled <= cfg_data;
      // the response stage refills the register itself when it drains
      if (out_valid && out_ready && state != ST_OUT) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            slot_q           <= in_data.slot;
            load_word        <= MAP_WORD_BITS'(in_data.word_data) & load_mask;
            sb_q             <= req_sb;
            w_q              <= req_word;
            res.granted_slot <= '0;
            res.free_slots   <= free_total;
            priority if (in_data.func == FUNC_ALLOC) begin
              op         <= OP_ALLOC;
              g_q        <= alloc_grp;
              state      <= go_alloc ? ST_SUM : ST_OUT;
              res.status <= go_alloc ? STATUS_OK : STATUS_NONE_FREE;
            end else if (in_data.func == FUNC_FREE) begin
              op    <= OP_FREE;
              g_q   <= req_grp;
              state <= go_free ? ST_SUM : ST_OUT;
              // slot zero is a silent no-op; other refused frees are flagged
              res.status <= (!go_free && in_data.slot != '0) ? STATUS_BITMAP_BAD
                                                              : STATUS_OK;
            end else if (in_data.func == FUNC_LOAD) begin
              op         <= OP_LOAD;
              g_q        <= req_grp;
              state      <= go_load ? ST_SUM : ST_OUT;
              res.status <= STATUS_OK;
            end else begin
              op         <= OP_LOAD;
              g_q        <= req_grp;
              state      <= ST_OUT;
              res.status <= STATUS_OK;
            end
          end
        end

        ST_SUM: begin
          sum_q <= sum_eff;
          bit_q <= rem_full[BIT_W-1:0];
          if (op == OP_ALLOC) begin
            sb_q <= sum_low;
            w_q  <= alloc_word;
          end
          state <= ST_WORD;
        end

        ST_WORD: begin
          free_total       <= free_after;
          res.free_slots   <= free_after;
          res.granted_slot <= (op == OP_ALLOC) ? SLOT_W'(granted_full) : '0;
          res.status       <= free_bad ? STATUS_BITMAP_BAD : STATUS_OK;
          if (map_we) grp_map[g_q] <= |sum_wdata;
          state <= ST_OUT;
        end

        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[tb/tb_swap_slot_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// tb_swap_slot_bitmap_allocator
// Self-checking bench for the swap slot allocator. A scoreboard keeps its own
// copy of the slot map, the free count and the enable bit, predicts every
// response when the request transaction is accepted, and compares each
// response field by field, in order. Directed checks come first, then random
// traffic under random backpressure on both sides, then a full-rate tail.
// ----------------------------------------------------------------------------
module tb_swap_slot_bitmap_allocator;
  import ssba_pkg::*;

  localparam int SLOTS       = 32768;
  localparam int WORD_BITS   = 32;
  localparam int MAP_WORDS   = SLOTS / WORD_BITS;
  localparam int SETTLE      = 8;       // settle time after the last owed response
  localparam int LONG_HOLD   = 80;      // output stall that must back up the input
  localparam int CYCLE_LIMIT = 200000;  // well above the slowest legal run

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;

  swap_slot_bitmap_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Scoreboard copy of the block state
  logic [WORD_BITS-1:0] map_shadow [MAP_WORDS];
  int                   free_shadow;
  bit                   enable_shadow;

  rsp_t                 rsp_owed [$];     // responses still to arrive, oldest first
  logic [SLOT_W-1:0]    granted_pool [$]; // slots handed out, candidates for a clean free

  int  errors;
  int  cycle_count;
  bit  src_idle_on;
  bit  snk_idle_on;
  int  snk_hold_req;                      // bumped once per requested long hold

  // --------------------------------------------------------------------------
  // Clock, cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: cycle limit reached, %0d responses outstanding", $time, rsp_owed.size());
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Scoreboard prediction: applies one request to the shadow state and returns
  // the response the block must give for it.
  // --------------------------------------------------------------------------
  function automatic rsp_t allocator_outcome(input req_t r);
    rsp_t                 o;
    logic [WORD_BITS-1:0] nv;
    int                   w;
    int                   b;
    bit                   found;
    o        = '0;
    o.status = STATUS_OK;
    found    = 1'b0;
    case (r.func)
      FUNC_ALLOC: begin
        // lowest free slot; bit 0 of word 0 is never set in the shadow
        o.status = STATUS_NONE_FREE;
        if (enable_shadow) begin
          for (w = 0; w < MAP_WORDS && !found; w++) begin
            if (map_shadow[w] != '0) begin
              b = 0;
              while (!map_shadow[w][b]) b++;
              map_shadow[w][b] = 1'b0;
              free_shadow--;
              o.granted_slot = SLOT_W'(w * WORD_BITS + b);
              o.status       = STATUS_OK;
              granted_pool.push_back(o.granted_slot);
              found = 1'b1;
            end
          end
        end
      end
      FUNC_FREE: begin
        // slot zero is a no-op; anything else must be in range, used, enabled
        if (r.slot != '0) begin
          if (enable_shadow && int'(r.slot) < SLOTS) begin
            w = r.slot / WORD_BITS;
            b = r.slot % WORD_BITS;
            if (map_shadow[w][b]) begin
              o.status = STATUS_BITMAP_BAD;
            end else begin
              map_shadow[w][b] = 1'b1;
              free_shadow++;
            end
          end else begin
            o.status = STATUS_BITMAP_BAD;
          end
        end
      end
      FUNC_LOAD: begin
        // works regardless of enable; slot 0 bit dropped
        if (int'(r.word_index) < MAP_WORDS) begin
          nv = r.word_data;
          if (r.word_index == '0) nv[0] = 1'b0;
          free_shadow = free_shadow - $countones(map_shadow[r.word_index]) + $countones(nv);
          map_shadow[r.word_index] = nv;
        end
      end
      default: ; // unused code: no state change, all-zero grant, ok status
    endcase
    o.free_slots = free_shadow[COUNT_W-1:0];
    return o;
  endfunction

  function automatic req_t make_req(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] s,
                                    input logic [INDEX_W-1:0] i, input logic [DATA_W-1:0] d);
    req_t r;
    r.func       = f;
    r.slot       = s;
    r.word_index = i;
    r.word_data  = d;
    return r;
  endfunction

  // Load contents: empty, full, dense random, or a single free slot
  function automatic logic [DATA_W-1:0] pick_word_data();
    logic [DATA_W-1:0] d;
    case ($urandom_range(0, 3))
      0:       d = '0;
      1:       d = '1;
      2:       d = $urandom;
      default: d = 32'd1 << $urandom_range(0, 31);
    endcase
    return d;
  endfunction

  function automatic req_t noisy_alloc();
    return make_req(FUNC_ALLOC, SLOT_W'($urandom_range(0, 32767)),
                    INDEX_W'($urandom_range(0, 1023)), $urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Valid stays high between back-to-back transactions; it only
  // drops for an idle burst or a drain, so each step sees one assignment.
  // --------------------------------------------------------------------------
  task automatic send_req(input req_t r);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    // accepted at this edge: predict now so the shadow follows request order
    rsp_owed.push_back(allocator_outcome(r));
  endtask

  // Sender goes quiet until every owed response is back, then a short settle
  task automatic wait_all_responses();
    in_valid <= 1'b0;
    while (rsp_owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Enable writes only happen with the block idle
  task automatic write_map_enable(input bit v);
    wait_all_responses();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid     <= 1'b0;
    enable_shadow  = v;
  endtask

  // --------------------------------------------------------------------------
  // Response side: random stall bursts, plus a long hold on request
  // --------------------------------------------------------------------------
  initial begin
    int holds_done;
    holds_done = 0;
    out_ready  = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (snk_hold_req != holds_done) begin
        holds_done = snk_hold_req;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (snk_idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Every response transaction is matched against the oldest prediction
  always @(posedge clk) begin : rsp_check
    rsp_t exp_rsp;
    if (rst === 1'b0 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (rsp_owed.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        exp_rsp = rsp_owed.pop_front();
        check_field("granted_slot", 32'(exp_rsp.granted_slot), 32'(out_data.granted_slot));
        check_field("status",       32'(exp_rsp.status),       32'(out_data.status));
        check_field("free_slots",   32'(exp_rsp.free_slots),   32'(out_data.free_slots));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Map disabled out of reset: nothing to grant, every nonzero free is bad, loads work
  task automatic test_disabled_after_reset();
    send_req(noisy_alloc());
    send_req(make_req(FUNC_FREE, '0, '0, '0));
    send_req(make_req(FUNC_FREE, 15'd5, '0, '0));
    send_req(make_req(FUNC_FREE, '1, '1, '1));
    send_req(make_req(FUNC_LOAD, '0, '0, '1));                 // slot 0 bit dropped
    send_req(make_req(FUNC_LOAD, '0, '1, 32'h8000_0001));      // top word, both ends
    send_req(noisy_alloc());
    send_req(make_req(FUNC_UNUSED, '1, '1, '1));               // unused code
  endtask

  // Enabled: grant order, double free, full map, top slot, far word
  task automatic test_alloc_free_basics();
    send_req(noisy_alloc());                                   // slot 1
    send_req(noisy_alloc());                                   // slot 2
    send_req(make_req(FUNC_FREE, 15'd1, '0, '0));
    send_req(make_req(FUNC_FREE, 15'd1, '0, '0));              // already free
    send_req(make_req(FUNC_FREE, 15'd32767, '0, '0));          // already free
    send_req(make_req(FUNC_FREE, '0, '1, '1));                 // ignored
    send_req(make_req(FUNC_LOAD, '0, '0, '0));
    send_req(make_req(FUNC_LOAD, '0, '1, '0));                 // map now empty
    send_req(noisy_alloc());                                   // none free
    send_req(make_req(FUNC_FREE, 15'd32767, '0, '0));
    send_req(noisy_alloc());                                   // top slot
    send_req(make_req(FUNC_LOAD, '0, 10'd512, 32'h0000_0001));
    send_req(noisy_alloc());                                   // first slot of word 512
  endtask

  // Toggling the enable keeps the map and the count
  task automatic test_enable_toggle();
    write_map_enable(1'b0);
    send_req(make_req(FUNC_FREE, 15'd100, '0, '0));            // bad while disabled
    send_req(noisy_alloc());
    write_map_enable(1'b1);
    send_req(make_req(FUNC_FREE, 15'd100, '0, '0));
    send_req(noisy_alloc());                                   // gets 100 back
  endtask

  // Output held off for a long stretch while requests keep coming
  task automatic test_output_stall();
    int i;
    snk_hold_req++;
    for (i = 0; i < 12; i++) begin
      if (i % 3 == 2) send_req(make_req(FUNC_FREE, SLOT_W'($urandom_range(1, 40)), '0, '0));
      else            send_req(noisy_alloc());
    end
  endtask

  // Mostly well-formed alloc/free pairs on a small window of words, plus noise
  task automatic test_random_traffic(input int n);
    int               i;
    int               k;
    int               pick;
    logic [SLOT_W-1:0] s;
    logic [INDEX_W-1:0] idx;
    for (i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 38) begin
        send_req(noisy_alloc());
      end else if (k < 70 && granted_pool.size() != 0) begin
        pick = $urandom_range(0, granted_pool.size() - 1);
        s    = granted_pool[pick];
        granted_pool.delete(pick);
        send_req(make_req(FUNC_FREE, s, INDEX_W'($urandom), $urandom));
      end else if (k < 80) begin
        send_req(make_req(FUNC_FREE, SLOT_W'($urandom_range(0, 32767)),
                          INDEX_W'($urandom), $urandom));
      end else if (k < 92) begin
        idx = ($urandom_range(0, 9) == 0) ? INDEX_W'($urandom_range(0, 1023))
                                          : INDEX_W'($urandom_range(0, 15));
        send_req(make_req(FUNC_LOAD, SLOT_W'($urandom), idx, pick_word_data()));
      end else if (k < 96) begin
        send_req(make_req(FUNC_FREE, '0, INDEX_W'($urandom), $urandom));
      end else begin
        send_req(make_req(FUNC_UNUSED, SLOT_W'($urandom), INDEX_W'($urandom), $urandom));
      end
    end
  endtask

  // Clear the map, seed a few words, then allocate until nothing is left
  task automatic test_exhaust();
    int i;
    for (i = 0; i < MAP_WORDS; i++) begin
      if (map_shadow[i] != '0) send_req(make_req(FUNC_LOAD, SLOT_W'($urandom), INDEX_W'(i), '0));
    end
    repeat (3) begin
      send_req(make_req(FUNC_LOAD, SLOT_W'($urandom), INDEX_W'($urandom_range(0, 15)),
                        $urandom & $urandom));
    end
    while (free_shadow != 0) send_req(noisy_alloc());
    send_req(noisy_alloc());                                   // none free
    granted_pool.delete();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    errors       = 0;
    src_idle_on  = 1'b1;
    snk_idle_on  = 1'b1;
    snk_hold_req = 0;
    free_shadow  = 0;
    enable_shadow = 1'b0;
    foreach (map_shadow[i]) map_shadow[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_disabled_after_reset();
    write_map_enable(1'b1);
    test_alloc_free_basics();
    test_enable_toggle();
    test_output_stall();
    test_random_traffic(550);
    wait_all_responses();
    test_exhaust();
    write_map_enable(1'b0);
    test_random_traffic(100);
    write_map_enable(1'b1);
    test_random_traffic(300);

    // full rate on both sides for the tail
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    test_random_traffic(220);

    wait_all_responses();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
